// ===== sv/bpms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpms_pkg
// types and codes shared by the battery pack mode supervisor
// ----------------------------------------------------------------------------
package bpms_pkg;

   typedef enum logic [2:0] {
      MODE_POWER_OFF = 3'd0,
      MODE_CHG_PRE   = 3'd1,
      MODE_DIS_PRE   = 3'd2,
      MODE_CHG_ON    = 3'd3,
      MODE_DIS_ON    = 3'd4,
      MODE_FAULT     = 3'd5,
      MODE_EMRG      = 3'd6,
      MODE_RESET     = 3'd7
   } mode_type;

   typedef enum logic [3:0] {
      STAT_INITIAL     = 4'd0,
      STAT_OFF         = 4'd1,
      STAT_PRE_ON      = 4'd2,
      STAT_ON          = 4'd3,
      STAT_CHARGING    = 4'd4,
      STAT_DISCHARGING = 4'd5,
      STAT_FAULT       = 4'd6,
      STAT_EMERGENCY   = 4'd7,
      STAT_GOING_RESET = 4'd8
   } status_type;

   typedef enum logic [1:0] {
      HV_NONE      = 2'd0,
      HV_OFF       = 2'd1,
      HV_ON        = 2'd2,
      HV_PRECHARGE = 2'd3
   } hv_type;

   // worst fault level codes, level three counts as none
   typedef enum logic [1:0] {
      LVL_NONE       = 2'd0,
      LVL_FAULT      = 2'd1,
      LVL_PROTECTION = 2'd2,
      LVL_UNUSED     = 2'd3
   } level_type;

   // protection sequence steps
   typedef enum logic [1:0] {
      PSTEP_HV_OFF    = 2'd0,
      PSTEP_WAIT_STOP = 2'd1,
      PSTEP_RESET     = 2'd2,
      PSTEP_UNUSED    = 2'd3
   } pstep_type;

   // emergency sequence steps
   typedef enum logic [1:0] {
      ESTEP_HV_OFF      = 2'd0,
      ESTEP_WAIT_RELEASE = 2'd1,
      ESTEP_RELEASED    = 2'd2,
      ESTEP_DONE        = 2'd3
   } estep_type;

   typedef struct packed {
      logic               engineer_mode;
      logic [2:0]         requested_mode;
      logic               stop_switch;
      logic [1:0]         worst_fault_level;
      logic               hv_is_off;
      logic signed [15:0] bus_current;
   } req_type;

   typedef struct packed {
      logic [2:0] chosen_mode;
      logic [3:0] system_status;
      logic [1:0] hv_command;
      logic       emergency_code_set;
      logic       emergency_code_clear;
      logic       fault_lamp_on;
      logic       reset_request;
   } rsp_type;

endpackage

// ===== sv/battery_pack_mode_supervisor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_pack_mode_supervisor
// per-tick mode choice with protection and emergency sequences
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+----------------------------
//   req_     | in        | req_valid/req_stall | bpms_pkg::req_type
//   rsp_     | out       | rsp_valid/rsp_stall | bpms_pkg::rsp_type
//
// one transfer in, one transfer out, through two registers
// (input register, then result register); one item per cycle sustained while the result is not stalled
// the decision logic between the two registers sets the pace
// reset (synchronous, active high) empties both stages and clears the
// protection and emergency step registers and their active flags
// a stalled result holds; the input register still takes a new transfer
// while it is empty, or while the result register is free or being emptied
//
module battery_pack_mode_supervisor (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bpms_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bpms_pkg::rsp_type rsp_data
);

   // pipeline registers
   logic              s1_valid_ff, s1_valid_in;
   bpms_pkg::req_type s1_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   bpms_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // sequence state
   bpms_pkg::pstep_type prot_step_ff, prot_step_in;
   logic                prot_active_ff, prot_active_in;
   bpms_pkg::estep_type emrg_step_ff, emrg_step_in;
   logic                emrg_active_ff, emrg_active_in;

   logic req_take;
   logic advance;

   // decision signals
   bpms_pkg::mode_type   mode;
   bpms_pkg::status_type status;
   bpms_pkg::hv_type     hv_cmd;
   bpms_pkg::level_type  level;
   bpms_pkg::pstep_type  prot_step;
   bpms_pkg::estep_type  emrg_step;
   logic                 code_set;
   logic                 lamp;
   logic                 reset_req;

   // handshake
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   assign level = bpms_pkg::level_type'(s1_data_ff.worst_fault_level);

   // steps fall back to zero when their sequence is not active
   assign prot_step = prot_active_ff ? prot_step_ff : bpms_pkg::PSTEP_HV_OFF;
   assign emrg_step = emrg_active_ff ? emrg_step_ff : bpms_pkg::ESTEP_HV_OFF;

   // mode choice by fixed priority
   always_comb begin
      code_set = 1'b0;
      priority if (s1_data_ff.engineer_mode) begin
         mode = bpms_pkg::mode_type'(s1_data_ff.requested_mode);
      end else if ((s1_data_ff.stop_switch && !prot_active_ff) || emrg_active_ff) begin
         mode     = bpms_pkg::MODE_EMRG;
         code_set = 1'b1;
      end else if ((level == bpms_pkg::LVL_PROTECTION && !emrg_active_ff)
                   || prot_active_ff) begin
         mode = bpms_pkg::MODE_FAULT;
      end else if (level == bpms_pkg::LVL_FAULT) begin
         mode = bpms_pkg::MODE_POWER_OFF;
      end else begin
         mode = bpms_pkg::mode_type'(s1_data_ff.requested_mode);
      end
   end

   // action on the chosen mode; status is set by every mode so no hold is kept
   always_comb begin
      hv_cmd         = bpms_pkg::HV_NONE;
      lamp           = 1'b0;
      reset_req      = 1'b0;
      status         = bpms_pkg::STAT_INITIAL;
      prot_step_in   = prot_step;
      prot_active_in = prot_active_ff;
      emrg_step_in   = emrg_step;
      emrg_active_in = emrg_active_ff;
      unique case (mode)
         bpms_pkg::MODE_RESET: begin
            status    = bpms_pkg::STAT_GOING_RESET;
            hv_cmd    = bpms_pkg::HV_OFF;
            reset_req = s1_data_ff.hv_is_off;
         end
         bpms_pkg::MODE_FAULT: begin
            status = bpms_pkg::STAT_FAULT;
            unique case (prot_step)
               bpms_pkg::PSTEP_HV_OFF: begin
                  prot_active_in = 1'b1;
                  hv_cmd         = bpms_pkg::HV_OFF;
                  if (s1_data_ff.hv_is_off) begin
                     prot_step_in = bpms_pkg::PSTEP_WAIT_STOP;
                  end
               end
               bpms_pkg::PSTEP_WAIT_STOP: begin
                  if (s1_data_ff.stop_switch) begin
                     prot_step_in = bpms_pkg::PSTEP_RESET;
                  end else begin
                     lamp = 1'b1;
                  end
               end
               bpms_pkg::PSTEP_RESET: begin
                  hv_cmd       = bpms_pkg::HV_OFF;
                  reset_req    = s1_data_ff.hv_is_off;
                  prot_step_in = bpms_pkg::PSTEP_HV_OFF;
               end
               bpms_pkg::PSTEP_UNUSED: begin
                  prot_step_in = bpms_pkg::PSTEP_HV_OFF;
               end
            endcase
         end
         bpms_pkg::MODE_EMRG: begin
            status = bpms_pkg::STAT_EMERGENCY;
            unique case (emrg_step)
               bpms_pkg::ESTEP_HV_OFF: begin
                  emrg_active_in = 1'b1;
                  hv_cmd         = bpms_pkg::HV_OFF;
                  if (s1_data_ff.hv_is_off) begin
                     emrg_step_in = bpms_pkg::ESTEP_WAIT_RELEASE;
                  end
               end
               bpms_pkg::ESTEP_WAIT_RELEASE: begin
                  if (!s1_data_ff.stop_switch) begin
                     emrg_step_in = bpms_pkg::ESTEP_RELEASED;
                  end
               end
               bpms_pkg::ESTEP_RELEASED: begin
                  emrg_step_in = bpms_pkg::ESTEP_DONE;
               end
               bpms_pkg::ESTEP_DONE: begin
                  // sequence finished, step stays put
                  emrg_active_in = 1'b0;
               end
            endcase
         end
         bpms_pkg::MODE_POWER_OFF: begin
            status = bpms_pkg::STAT_OFF;
            hv_cmd = bpms_pkg::HV_OFF;
         end
         bpms_pkg::MODE_CHG_ON, bpms_pkg::MODE_DIS_ON: begin
            hv_cmd = bpms_pkg::HV_ON;
            // only the sign and zero of the current matter
            priority if (s1_data_ff.bus_current == 16'sd0) begin
               status = bpms_pkg::STAT_ON;
            end else if (!s1_data_ff.bus_current[15]) begin
               status = bpms_pkg::STAT_CHARGING;
            end else begin
               status = bpms_pkg::STAT_DISCHARGING;
            end
         end
         bpms_pkg::MODE_CHG_PRE, bpms_pkg::MODE_DIS_PRE: begin
            status = bpms_pkg::STAT_PRE_ON;
            hv_cmd = bpms_pkg::HV_PRECHARGE;
         end
      endcase
   end

   // result word; clear pulses whenever emergency was not active at entry
   always_comb begin
      rsp_data_in.chosen_mode          = mode;
      rsp_data_in.system_status        = status;
      rsp_data_in.hv_command           = hv_cmd;
      rsp_data_in.emergency_code_set   = code_set;
      rsp_data_in.emergency_code_clear = !emrg_active_ff;
      rsp_data_in.fault_lamp_on        = lamp;
      rsp_data_in.reset_request        = reset_req;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         prot_step_ff   <= bpms_pkg::PSTEP_HV_OFF;
         prot_active_ff <= 1'b0;
         emrg_step_ff   <= bpms_pkg::ESTEP_HV_OFF;
         emrg_active_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            prot_step_ff   <= prot_step_in;
            prot_active_ff <= prot_active_in;
            emrg_step_ff   <= emrg_step_in;
            emrg_active_ff <= emrg_active_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // a protection step other than zero only exists with protection active
   a_prot_step_active: assert property (@(posedge clock) disable iff (reset)
      prot_step_ff != bpms_pkg::PSTEP_HV_OFF |-> prot_active_ff)
      else $error("protection step without active flag");

   // fault lamp only during the fault mode
   a_lamp_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.fault_lamp_on |->
         rsp_data_ff.chosen_mode == bpms_pkg::MODE_FAULT)
      else $error("fault lamp outside fault mode");

   // a reset request always comes with high voltage off
   a_reset_hv_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.reset_request |->
         rsp_data_ff.hv_command == bpms_pkg::HV_OFF)
      else $error("reset request without hv off");

   // the emergency code is raised only in emergency mode
   a_code_set_emrg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.emergency_code_set |->
         rsp_data_ff.chosen_mode == bpms_pkg::MODE_EMRG)
      else $error("emergency code outside emergency mode");

   // sequence state moves only when an item passes to the result register
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(prot_step_ff) && $stable(emrg_step_ff)
         && $stable(prot_active_ff) && $stable(emrg_active_ff))
      else $error("sequence state changed without an item");
`endif

endmodule
